/* design/vca_pkg.sv */
// Shared types, constants and helper functions for the Voronoi cell area block.
package vca_pkg;

  localparam int CoordW       = 24;
  localparam int IdW          = 20;
  localparam int IdBits       = 20;
  localparam int AreaW        = 53;
  localparam int SumW         = 64;
  localparam int ProdW        = 2 * CoordW;
  localparam int TermW        = ProdW + 1;
  localparam int MaxTriangles = 64;
  localparam int CntW         = $clog2(MaxTriangles + 1);
  localparam int MinTriangles = 3;
  localparam int QueueDepth   = 4;
  localparam int QPtrW        = $clog2(QueueDepth);

  localparam logic signed [SumW-1:0] SumMax = {1'b0, {(SumW-1){1'b1}}};
  localparam logic [AreaW-1:0]       AreaMax = {AreaW{1'b1}};

  typedef struct packed {
    logic signed [CoordW-1:0] center_x;
    logic signed [CoordW-1:0] center_y;
    logic [IdW-1:0]           vertex_a;
    logic [IdW-1:0]           vertex_b;
    logic [IdW-1:0]           vertex_c;
    logic                     zero_exposure;
    logic                     last_triangle;
  } tri_word_t;

  typedef struct packed {
    logic [AreaW-1:0] cell_area;
    logic             at_edge;
  } area_word_t;

  typedef struct packed {
    logic signed [CoordW-1:0] x;
    logic signed [CoordW-1:0] y;
  } point_t;

  typedef logic [2:0][IdW-1:0] verts_t;

  typedef enum logic [1:0] {
    ACC_CLEAR,
    ACC_ADD,
    ACC_KEEP
  } acc_op_e;

  // one classified triangle, handed from front to back
  typedef struct packed {
    point_t  prev_c;
    point_t  cur_c;
    point_t  first_c;
    acc_op_e op;
    logic    fin;
    logic    edge_flag;
  } job_t;

  // at least two of the 3x3 id pairs equal
  function automatic logic linked(verts_t p, verts_t q);
    logic [1:0] n;
    n = 2'd0;
    for (int i = 0; i < 3; i++) begin
      for (int j = 0; j < 3; j++) begin
        if (p[i][IdBits-1:0] == q[j][IdBits-1:0] && n != 2'd2) begin
          n = n + 2'd1;
        end
      end
    end
    return n == 2'd2;
  endfunction

  // add with symmetric saturation at +/-(2^63 - 1)
  function automatic logic signed [SumW-1:0] sat_add(logic signed [SumW-1:0] a,
                                                     logic signed [TermW-1:0] b);
    logic signed [SumW:0] r;
    logic signed [SumW:0] hi;
    r  = (SumW+1)'(a) + (SumW+1)'(b);
    hi = (SumW+1)'(SumMax);
    if (r > hi) begin
      return SumMax;
    end else if (r < -hi) begin
      return -SumMax;
    end
    return r[SumW-1:0];
  endfunction

endpackage

/* design/vca_front.sv */
// Front end: accepts triangles, checks links and classifies each for the back end.
module vca_front
  import vca_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_stall_o,
  input  tri_word_t in_word_i,
  input  logic      q_full_i,
  output logic      push_o,
  output job_t      job_o
);

  logic [CntW-1:0] cnt_q, cnt_d, cnt_inc;
  logic            edge_q, edge_d;
  point_t          first_c_q, prev_c_q, cur_c, first_c;
  verts_t          first_v_q, prev_v_q, cur_v, first_v;
  logic            accept, is_first, link_prev, link_first, edge_now;
  acc_op_e         op;

  assign in_stall_o = q_full_i;
  assign accept     = in_valid_i && !q_full_i;
  assign push_o     = accept;

  assign cur_c    = '{x: in_word_i.center_x, y: in_word_i.center_y};
  assign cur_v    = {in_word_i.vertex_c, in_word_i.vertex_b, in_word_i.vertex_a};
  assign is_first = (cnt_q == '0);
  assign first_c  = is_first ? cur_c : first_c_q;
  assign first_v  = is_first ? cur_v : first_v_q;
  assign cnt_inc  = (cnt_q == CntW'(MaxTriangles)) ? cnt_q : cnt_q + 1'b1;

  assign link_prev  = linked(prev_v_q, cur_v);
  assign link_first = linked(cur_v, first_v);

  always_comb begin
    if (is_first) begin
      op       = ACC_CLEAR;
      edge_now = in_word_i.zero_exposure;
    end else if (!edge_q && link_prev) begin
      op       = ACC_ADD;
      edge_now = 1'b0;
    end else begin
      op       = ACC_KEEP;
      edge_now = 1'b1;
    end
  end

  always_comb begin
    job_o.prev_c    = prev_c_q;
    job_o.cur_c     = cur_c;
    job_o.first_c   = first_c;
    job_o.op        = op;
    job_o.fin       = in_word_i.last_triangle;
    job_o.edge_flag = edge_now || (cnt_inc < CntW'(MinTriangles)) || !link_first;
  end

  always_comb begin
    cnt_d  = cnt_q;
    edge_d = edge_q;
    if (accept) begin
      cnt_d  = in_word_i.last_triangle ? '0 : cnt_inc;
      edge_d = in_word_i.last_triangle ? 1'b0 : edge_now;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      edge_q <= 1'b0;
    end else begin
      cnt_q  <= cnt_d;
      edge_q <= edge_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      prev_c_q <= cur_c;
      prev_v_q <= cur_v;
      if (is_first) begin
        first_c_q <= cur_c;
        first_v_q <= cur_v;
      end
    end
  end

endmodule

/* design/vca_queue.sv */
// Short queue of classified triangles between front and back end.
module vca_queue
  import vca_pkg::*;
(
  input  logic clk_i,
  input  logic rst_ni,
  input  logic push_i,
  input  job_t job_i,
  output logic full_o,
  input  logic pop_i,
  output logic valid_o,
  output job_t job_o
);

  job_t             mem_q [QueueDepth];
  logic [QPtrW-1:0] wr_q, wr_d, rd_q, rd_d;
  logic [QPtrW:0]   cnt_q, cnt_d;
  logic             do_pop;

  assign full_o  = (cnt_q == (QPtrW+1)'(QueueDepth));
  assign valid_o = (cnt_q != '0);
  assign job_o   = mem_q[rd_q];
  assign do_pop  = pop_i && valid_o;

  always_comb begin
    wr_d  = push_i ? wr_q + 1'b1 : wr_q;
    rd_d  = do_pop ? rd_q + 1'b1 : rd_q;
    cnt_d = cnt_q;
    if (push_i && !do_pop) begin
      cnt_d = cnt_q + 1'b1;
    end else if (!push_i && do_pop) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_q] <= job_i;
    end
  end

endmodule

/* design/vca_back.sv */
// Back end: cross products, running sum, closing term and area output register.
module vca_back
  import vca_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       q_valid_i,
  input  job_t       job_i,
  output logic       q_pop_o,
  output logic       out_valid_o,
  input  logic       out_stall_i,
  output area_word_t out_word_o
);

  logic adv;

  // stage 1: products
  logic                    s1_valid_q;
  acc_op_e                 s1_op_q;
  logic                    s1_fin_q, s1_edge_q;
  logic signed [ProdW-1:0] s1_p1_q, s1_p2_q, s1_p3_q, s1_p4_q;
  // stage 2: cross terms
  logic                    s2_valid_q;
  acc_op_e                 s2_op_q;
  logic                    s2_fin_q, s2_edge_q;
  logic signed [TermW-1:0] s2_t1_q, s2_t2_q;
  // stage 3: accumulate
  logic signed [SumW-1:0]  acc_q, acc_d;
  logic                    s3_valid_q, s3_fin_q, s3_edge_q;
  logic signed [SumW-1:0]  s3_sum_q;
  logic signed [TermW-1:0] s3_t2_q;
  // stage 4: closing term
  logic                    s4_valid_q, s4_fin_q, s4_edge_q;
  logic signed [SumW-1:0]  s4_sum_q;
  // output
  logic                    out_valid_q;
  area_word_t              out_word_q, out_word_d;
  logic [SumW-1:0]         mag;

  assign adv     = !out_valid_q || !out_stall_i;
  assign q_pop_o = adv && q_valid_i;

  always_comb begin
    acc_d = acc_q;
    unique case (s2_op_q)
      ACC_CLEAR: acc_d = '0;
      ACC_ADD:   acc_d = sat_add(acc_q, s2_t1_q);
      ACC_KEEP:  acc_d = acc_q;
      default:   acc_d = acc_q;
    endcase
  end

  assign mag = s4_sum_q[SumW-1] ? SumW'(-s4_sum_q) : SumW'(s4_sum_q);

  always_comb begin
    out_word_d.at_edge = s4_edge_q;
    if (s4_edge_q) begin
      out_word_d.cell_area = '0;
    end else if (|mag[SumW-2:AreaW+1]) begin
      out_word_d.cell_area = AreaMax;
    end else begin
      out_word_d.cell_area = mag[AreaW:1];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      s2_valid_q  <= 1'b0;
      s3_valid_q  <= 1'b0;
      s4_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
      acc_q       <= '0;
    end else if (adv) begin
      s1_valid_q  <= q_valid_i;
      s2_valid_q  <= s1_valid_q;
      s3_valid_q  <= s2_valid_q;
      s4_valid_q  <= s3_valid_q;
      out_valid_q <= s4_valid_q && s4_fin_q;
      if (s2_valid_q) begin
        acc_q <= acc_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      s1_op_q   <= job_i.op;
      s1_fin_q  <= job_i.fin;
      s1_edge_q <= job_i.edge_flag;
      s1_p1_q   <= $signed(job_i.prev_c.x) * $signed(job_i.cur_c.y);
      s1_p2_q   <= $signed(job_i.cur_c.x) * $signed(job_i.prev_c.y);
      s1_p3_q   <= $signed(job_i.cur_c.x) * $signed(job_i.first_c.y);
      s1_p4_q   <= $signed(job_i.first_c.x) * $signed(job_i.cur_c.y);

      s2_op_q   <= s1_op_q;
      s2_fin_q  <= s1_fin_q;
      s2_edge_q <= s1_edge_q;
      s2_t1_q   <= TermW'(s1_p1_q) - TermW'(s1_p2_q);
      s2_t2_q   <= TermW'(s1_p3_q) - TermW'(s1_p4_q);

      s3_fin_q  <= s2_fin_q;
      s3_edge_q <= s2_edge_q;
      s3_sum_q  <= acc_d;
      s3_t2_q   <= s2_t2_q;

      s4_fin_q  <= s3_fin_q;
      s4_edge_q <= s3_edge_q;
      s4_sum_q  <= sat_add(s3_sum_q, s3_t2_q);

      out_word_q <= out_word_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_word_o  = out_word_q;

endmodule

/* design/voronoi_cell_area_top.sv */
// Top level of the Voronoi cell area block: front end, queue and back end.
//
//   channel | valid       | stall       | word
//   --------+-------------+-------------+------------------------
//   in      | in_valid_i  | in_stall_o  | in_word_i  (tri_word_t)
//   out     | out_valid_o | out_stall_i | out_word_o (area_word_t)
//
// One triangle word per cycle, sustained while out_stall_i is low.
// A result passes from the queue through stages 1 to 4 and the output register before it is shown.
// Reset clears the event state, the queue and all stage valid bits.
// in_stall_o is high while the four-entry queue is full.
// out_stall_i freezes the back end pipeline while a result is shown; the front keeps filling the queue.
module voronoi_cell_area_top
  import vca_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  tri_word_t  in_word_i,
  output logic       out_valid_o,
  input  logic       out_stall_i,
  output area_word_t out_word_o
);

  logic push, q_full, q_valid, q_pop;
  job_t push_job, pop_job;

  vca_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_word_i  (in_word_i),
    .q_full_i   (q_full),
    .push_o     (push),
    .job_o      (push_job)
  );

  vca_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .job_i   (push_job),
    .full_o  (q_full),
    .pop_i   (q_pop),
    .valid_o (q_valid),
    .job_o   (pop_job)
  );

  vca_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .q_valid_i   (q_valid),
    .job_i       (pop_job),
    .q_pop_o     (q_pop),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_word_o  (out_word_o)
  );

endmodule

/* design/vca_checker.sv */
// Port-level checks for the Voronoi cell area block, bound to the top level.
module vca_checker
  import vca_pkg::*;
(
  input logic       clk_i,
  input logic       rst_ni,
  input logic       in_valid_i,
  input logic       in_stall_o,
  input tri_word_t  in_word_i,
  input logic       out_valid_o,
  input logic       out_stall_i,
  input area_word_t out_word_o
);

  logic [3:0] pend_q, pend_d;
  logic       inc, dec;

  assign inc = in_valid_i && !in_stall_o && in_word_i.last_triangle;
  assign dec = out_valid_o && !out_stall_i;

  always_comb begin
    pend_d = pend_q;
    if (inc && !dec) begin
      pend_d = pend_q + 4'd1;
    end else if (!inc && dec) begin
      pend_d = pend_q - 4'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_q <= '0;
    end else begin
      pend_q <= pend_d;
    end
  end

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(out_word_o))
    else $error("output word changed while stalled");

  a_edge_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_word_o.at_edge |-> out_word_o.cell_area == '0)
    else $error("edge event with nonzero area");

  a_no_orphan: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> pend_q != 4'd0)
    else $error("result without a pending last triangle");

endmodule

bind voronoi_cell_area_top vca_checker u_vca_checker (.*);
